@@ rtl/core/u8bmp_pkg.sv @@
`default_nettype none

package u8bmp_pkg;

    localparam int unsigned BUF_DEPTH = 4;

    localparam logic [15:0] REPLACEMENT  = 16'hFFFD;
    localparam logic [15:0] NONCHAR_LO   = 16'hFDD0;
    localparam logic [15:0] NONCHAR_HI   = 16'hFDEF;
    localparam logic [15:0] NONCHAR_FFFE = 16'hFFFE;
    localparam logic [15:0] NONCHAR_FFFF = 16'hFFFF;

    localparam logic [7:0] LEAD_MIN  = 8'hC2;
    localparam logic [7:0] LEAD_MAX  = 8'hF4;
    localparam logic [7:0] CONT_MIN  = 8'h80;
    localparam logic [7:0] CONT_MAX  = 8'hBF;
    localparam logic [7:0] LEAD_E0   = 8'hE0;
    localparam logic [7:0] LEAD_ED   = 8'hED;
    localparam logic [7:0] LEAD_F0   = 8'hF0;
    localparam logic [7:0] LEAD_F4   = 8'hF4;
    localparam logic [7:0] E0_MIN    = 8'hA0;
    localparam logic [7:0] ED_MAX    = 8'h9F;
    localparam logic [7:0] F0_MIN    = 8'h90;
    localparam logic [7:0] F4_MAX    = 8'h8F;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_INVALID = 2'd1,
        ERR_NON_BMP = 2'd2,
        ERR_NONCHAR = 2'd3
    } err_t;

    // Controller to datapath.
    typedef struct packed {
        logic sel_input;  // working buffer includes the byte on the input port
        logic store;      // take the input byte into the buffer without a result
        logic advance;    // commit one result and consume its bytes
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic stop;       // head sequence must wait for more bytes
        logic last;       // the result being formed ends the current transaction's run
        logic out_free;   // the output register can be loaded this cycle
    } status_t;

    // Sequence length implied by a lead byte, 1 to 4.
    function automatic logic [2:0] seq_len(input logic [7:0] b0);
        logic [2:0] len;
        if (b0 < 8'hC0) begin
            len = 3'd1;
        end else if (b0 < 8'hE0) begin
            len = 3'd2;
        end else if (b0 < 8'hF0) begin
            len = 3'd3;
        end else begin
            len = 3'd4;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/u8bmp_ctrl.sv @@
`default_nettype none

module u8bmp_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output      logic              s_tready,
    input  wire u8bmp_pkg::status_t stat,
    output      u8bmp_pkg::cmd_t   cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.sel_input = 1'b1;
                if (s_tvalid && s_tready) begin
                    if (stat.stop) begin
                        cmd.store = 1'b1;
                    end else if (stat.out_free) begin
                        cmd.advance = 1'b1;
                        if (!stat.last) begin
                            state_next = ST_BUSY;
                        end
                    end else begin
                        // Output still occupied: park the whole sequence.
                        cmd.store  = 1'b1;
                        state_next = ST_BUSY;
                    end
                end
            end
            ST_BUSY: begin
                if (stat.stop) begin
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.advance = 1'b1;
                    if (stat.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_tready = ready_reg && (state_reg == ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/u8bmp_dp.sv @@
`default_nettype none

module u8bmp_dp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [7:0]         s_tdata,
    input  wire logic               s_tlast,
    output      logic [23:0]        m_tdata,
    output      logic               m_tvalid,
    input  wire logic               m_tready,
    output      logic               m_tlast,
    output      logic               m_tuser,
    input  wire u8bmp_pkg::cmd_t    cmd,
    output      u8bmp_pkg::status_t stat
);

    logic [7:0]  buf_reg  [u8bmp_pkg::BUF_DEPTH];
    logic [7:0]  buf_next [u8bmp_pkg::BUF_DEPTH];
    logic [2:0]  cnt_reg;
    logic        eos_reg;
    logic [1:0]  sticky_reg;

    logic [15:0] code_reg;
    logic [1:0]  err_reg;
    logic [1:0]  first_reg;
    logic        run_last_reg;
    logic        str_last_reg;
    logic        out_valid_reg;

    logic [7:0]  w      [u8bmp_pkg::BUF_DEPTH];
    logic [7:0]  sh     [u8bmp_pkg::BUF_DEPTH];
    logic [2:0]  w_cnt;
    logic        w_eos;
    logic [2:0]  len;
    logic [2:0]  used;
    logic [2:0]  rem;
    logic [2:0]  len_next;
    logic        wf;
    logic        short_seq;
    logic [15:0] cu_raw;
    logic [15:0] cu;
    logic [1:0]  err;
    logic [1:0]  sticky_next;

    // Working view: parked bytes, plus the incoming byte when one is offered.
    always_comb begin
        for (int i = 0; i < u8bmp_pkg::BUF_DEPTH; i++) begin
            if (cmd.sel_input && (cnt_reg == 3'(i))) begin
                w[i] = s_tdata;
            end else begin
                w[i] = buf_reg[i];
            end
        end
        w_cnt = cmd.sel_input ? (cnt_reg + 3'd1) : cnt_reg;
        w_eos = cmd.sel_input ? s_tlast : eos_reg;
    end

    // Strict well-formedness of the head sequence.
    always_comb begin
        len       = u8bmp_pkg::seq_len(w[0]);
        short_seq = (w_cnt < len);
        wf        = 1'b1;
        if (w[0] < 8'h80) begin
            wf = 1'b1;
        end else if (w[0] < u8bmp_pkg::LEAD_MIN || w[0] > u8bmp_pkg::LEAD_MAX) begin
            wf = 1'b0;
        end else begin
            if (w[0] == u8bmp_pkg::LEAD_E0 && w[1] < u8bmp_pkg::E0_MIN) wf = 1'b0;
            if (w[0] == u8bmp_pkg::LEAD_ED && w[1] > u8bmp_pkg::ED_MAX) wf = 1'b0;
            if (w[0] == u8bmp_pkg::LEAD_F0 && w[1] < u8bmp_pkg::F0_MIN) wf = 1'b0;
            if (w[0] == u8bmp_pkg::LEAD_F4 && w[1] > u8bmp_pkg::F4_MAX) wf = 1'b0;
            for (int i = 1; i < u8bmp_pkg::BUF_DEPTH; i++) begin
                if (3'(i) < len &&
                    (w[i] < u8bmp_pkg::CONT_MIN || w[i] > u8bmp_pkg::CONT_MAX)) begin
                    wf = 1'b0;
                end
            end
        end
    end

    // Code point and error classification.
    always_comb begin
        case (len)
            3'd1:    cu_raw = {8'h00, w[0]};
            3'd2:    cu_raw = {5'b00000, w[0][4:0], w[1][5:0]};
            3'd3:    cu_raw = {w[0][3:0], w[1][5:0], w[2][5:0]};
            default: cu_raw = u8bmp_pkg::REPLACEMENT;
        endcase
        used = 3'd1;
        cu   = u8bmp_pkg::REPLACEMENT;
        err  = u8bmp_pkg::ERR_INVALID;
        if (!short_seq && wf) begin
            used = len;
            if (len == 3'd4) begin
                err = u8bmp_pkg::ERR_NON_BMP;
            end else if (cu_raw == u8bmp_pkg::NONCHAR_FFFE || cu_raw == u8bmp_pkg::NONCHAR_FFFF
                         || (cu_raw >= u8bmp_pkg::NONCHAR_LO
                             && cu_raw <= u8bmp_pkg::NONCHAR_HI)) begin
                err = u8bmp_pkg::ERR_NONCHAR;
            end else begin
                err = u8bmp_pkg::ERR_NONE;
                cu  = cu_raw;
            end
        end
        sticky_next = (sticky_reg == u8bmp_pkg::ERR_NONE) ? err : sticky_reg;
    end

    // Buffer after consuming the head, and a look at what follows it.
    always_comb begin
        for (int i = 0; i < u8bmp_pkg::BUF_DEPTH; i++) begin
            sh[i] = w[i];
        end
        case (used)
            3'd1: begin
                sh[0] = w[1];
                sh[1] = w[2];
                sh[2] = w[3];
            end
            3'd2: begin
                sh[0] = w[2];
                sh[1] = w[3];
            end
            3'd3: begin
                sh[0] = w[3];
            end
            default: begin
            end
        endcase
        rem      = w_cnt - used;
        len_next = u8bmp_pkg::seq_len(sh[0]);
    end

    assign stat.stop     = (w_cnt == 3'd0) || (short_seq && !w_eos);
    assign stat.last     = (rem == 3'd0) || (!w_eos && rem < len_next);
    assign stat.out_free = !out_valid_reg || m_tready;

    always_comb begin
        for (int i = 0; i < u8bmp_pkg::BUF_DEPTH; i++) begin
            buf_next[i] = buf_reg[i];
            if (cmd.advance) begin
                buf_next[i] = sh[i];
            end else if (cmd.store) begin
                buf_next[i] = w[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < u8bmp_pkg::BUF_DEPTH; i++) begin
            buf_reg[i] <= buf_next[i];
        end
        if (cmd.advance) begin
            code_reg     <= cu;
            err_reg      <= err;
            first_reg    <= sticky_next;
            run_last_reg <= stat.last;
            str_last_reg <= stat.last && w_eos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= 3'd0;
            eos_reg       <= 1'b0;
            sticky_reg    <= u8bmp_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.advance) begin
                cnt_reg <= rem;
                eos_reg <= w_eos;
                if (stat.last && w_eos) begin
                    sticky_reg <= u8bmp_pkg::ERR_NONE;
                end else begin
                    sticky_reg <= sticky_next;
                end
            end else if (cmd.store) begin
                cnt_reg <= w_cnt;
                eos_reg <= w_eos;
            end
            if (cmd.advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tdata  = {4'b0000, first_reg, err_reg, code_reg};
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = str_last_reg;
    assign m_tuser  = run_last_reg;

`ifndef ASSERT_OFF
    a_adv_not_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.advance |-> !stat.stop)
        else $error("result committed while the head sequence was waiting");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4)
        else $error("buffer count out of range");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.advance && stat.last && w_eos) |=> (cnt_reg == 3'd0 && sticky_reg == 2'd0))
        else $error("string end left state behind");

    a_err_repl: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && err_reg != u8bmp_pkg::ERR_NONE)
            |-> (code_reg == u8bmp_pkg::REPLACEMENT && first_reg != u8bmp_pkg::ERR_NONE))
        else $error("error result without replacement or first error");
`endif

endmodule

`default_nettype wire

@@ rtl/core/utf8_decoder_bmp_core.sv @@
// Channel | Direction | Signals                     | Contents
// s_      | in        | tvalid tready tdata tlast   | tdata[7:0] data_byte, tlast end_of_string
// m_      | out       | tvalid tready tdata tlast   | tdata[15:0] code_unit, [17:16] error_code,
//         |           | tuser                       | [19:18] first_error; tlast string_last;
//         |           |                             | tuser run_last
//
// A byte that gives several results holds off the next byte until each of those results
// has been loaded into the output register.
// The input waits while bytes of an earlier transaction still have results to deliver.
// Reset clears the buffer count, the sticky error and the output valid flag; the input
// is first ready once its registered ready flag is set after reset is released.
// Back-pressure on m_ holds the result register; a byte offered meanwhile is still
// taken and parked, after which the input waits until the results have entered the output register.

`default_nettype none

module utf8_decoder_bmp_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [23:0] m_tdata,   // [15:0] code_unit, [17:16] error_code,
                                        // [19:18] first_error, [23:20] zero
    output      logic        m_tlast,
    output      logic        m_tuser    // [0] run_last
);

    // The controller decides, each cycle, whether the head of the byte buffer is
    // parked, turned into a result, or left waiting for more bytes or for the output register.
    u8bmp_pkg::cmd_t    cmd;
    u8bmp_pkg::status_t stat;

    u8bmp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds up to four bytes, validates and decodes the head
    // sequence, and carries the registered result transaction.
    u8bmp_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire

@@ test/utf8_decoder_bmp_core_test.sv @@
`timescale 1ns / 100ps

// One decoded BMP code unit as the result channel should carry it.
typedef struct {
    logic [15:0]          code_unit;
    u8bmp_pkg::err_t      error_code;
    u8bmp_pkg::err_t      first_error;
    logic                 run_last;
    logic                 string_last;
} bmp_unit_t;

// Holds a private copy of the decoder state, works out the code units that each
// accepted byte must produce and compares them, in order, with what comes out.
class bmp_decode_checker;
    logic [7:0]       held_bytes [3];
    int unsigned      held_count;
    u8bmp_pkg::err_t  string_error;
    bmp_unit_t        expected_units [$];
    int unsigned      fail_count;

    function new();
        held_count   = 0;
        string_error = u8bmp_pkg::ERR_NONE;
        fail_count   = 0;
    endfunction

    function int unsigned outstanding();
        return expected_units.size();
    endfunction

    // Bytes in the sequence, judged from its lead byte alone.
    function int unsigned lead_length(logic [7:0] b0);
        if (b0 < 8'hC0) return 1;
        if (b0 < 8'hE0) return 2;
        if (b0 < 8'hF0) return 3;
        return 4;
    endfunction

    // Strict well-formedness of a complete sequence of len bytes.
    function bit legal_sequence(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                logic [7:0] b3, int unsigned len);
        if (b0 < 8'h80) return 1'b1;
        if (b0 < u8bmp_pkg::LEAD_MIN || b0 > u8bmp_pkg::LEAD_MAX) return 1'b0;
        if (b0 == u8bmp_pkg::LEAD_E0 && b1 < u8bmp_pkg::E0_MIN) return 1'b0;
        if (b0 == u8bmp_pkg::LEAD_ED && b1 > u8bmp_pkg::ED_MAX) return 1'b0;
        if (b0 == u8bmp_pkg::LEAD_F0 && b1 < u8bmp_pkg::F0_MIN) return 1'b0;
        if (b0 == u8bmp_pkg::LEAD_F4 && b1 > u8bmp_pkg::F4_MAX) return 1'b0;
        if (len > 1 && (b1 < u8bmp_pkg::CONT_MIN || b1 > u8bmp_pkg::CONT_MAX)) return 1'b0;
        if (len > 2 && (b2 < u8bmp_pkg::CONT_MIN || b2 > u8bmp_pkg::CONT_MAX)) return 1'b0;
        if (len > 3 && (b3 < u8bmp_pkg::CONT_MIN || b3 > u8bmp_pkg::CONT_MAX)) return 1'b0;
        return 1'b1;
    endfunction

    // Decodes one accepted byte and queues the code units it releases.
    function void take_byte(logic [7:0] data, logic eos);
        logic [7:0]      work [7];
        int unsigned     n;
        int unsigned     pos;
        int unsigned     len;
        int unsigned     used;
        logic [15:0]     cu;
        u8bmp_pkg::err_t err;
        bmp_unit_t       unit;
        bmp_unit_t       prev;
        bit              have_prev;

        work = '{default: 8'h00};
        for (int i = 0; i < held_count; i++) work[i] = held_bytes[i];
        work[held_count] = data;
        n         = held_count + 1;
        pos       = 0;
        have_prev = 1'b0;

        while (pos < n) begin
            len  = lead_length(work[pos]);
            used = 1;
            if (n - pos < len && !eos) break;
            if (n - pos < len ||
                !legal_sequence(work[pos], work[pos + 1], work[pos + 2], work[pos + 3], len)) begin
                err = u8bmp_pkg::ERR_INVALID;
                cu  = u8bmp_pkg::REPLACEMENT;
            end else begin
                used = len;
                err  = u8bmp_pkg::ERR_NONE;
                case (len)
                    1: cu = {8'h00, work[pos]};
                    2: cu = {5'b0, work[pos][4:0], work[pos + 1][5:0]};
                    3: cu = {work[pos][3:0], work[pos + 1][5:0], work[pos + 2][5:0]};
                    default: begin
                        cu  = u8bmp_pkg::REPLACEMENT;
                        err = u8bmp_pkg::ERR_NON_BMP;
                    end
                endcase
                if (err == u8bmp_pkg::ERR_NONE &&
                    (cu == u8bmp_pkg::NONCHAR_FFFE || cu == u8bmp_pkg::NONCHAR_FFFF ||
                     (cu >= u8bmp_pkg::NONCHAR_LO && cu <= u8bmp_pkg::NONCHAR_HI))) begin
                    err = u8bmp_pkg::ERR_NONCHAR;
                    cu  = u8bmp_pkg::REPLACEMENT;
                end
            end
            if (string_error == u8bmp_pkg::ERR_NONE) string_error = err;

            unit.code_unit   = cu;
            unit.error_code  = err;
            unit.first_error = string_error;
            unit.run_last    = 1'b0;
            unit.string_last = 1'b0;
            // Hold each unit back by one so that the last of the run can be marked.
            if (have_prev) expected_units = {expected_units, prev};
            prev      = unit;
            have_prev = 1'b1;
            pos += used;
        end

        if (have_prev) begin
            prev.run_last    = 1'b1;
            prev.string_last = eos;
            expected_units   = {expected_units, prev};
        end

        if (eos) begin
            held_count   = 0;
            string_error = u8bmp_pkg::ERR_NONE;
        end else begin
            for (int i = 0; i < n - pos; i++) held_bytes[i] = work[pos + i];
            held_count = n - pos;
        end
    endfunction

    task report(string what);
        fail_count++;
        if (fail_count <= 40) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_unit(logic [23:0] tdata, logic tlast, logic tuser);
        bmp_unit_t want;
        if (expected_units.size() == 0) begin
            report($sformatf("result %h with nothing expected", tdata));
            return;
        end
        want = expected_units.pop_front();
        if (tdata[15:0] !== want.code_unit)
            report($sformatf("code_unit %h, expected %h", tdata[15:0], want.code_unit));
        if (tdata[17:16] !== want.error_code)
            report($sformatf("error_code %0d, expected %0d", tdata[17:16], want.error_code));
        if (tdata[19:18] !== want.first_error)
            report($sformatf("first_error %0d, expected %0d", tdata[19:18], want.first_error));
        if (tdata[23:20] !== 4'd0)
            report($sformatf("padding bits %h are not zero", tdata[23:20]));
        if (tuser !== want.run_last)
            report($sformatf("run_last %b, expected %b", tuser, want.run_last));
        if (tlast !== want.string_last)
            report($sformatf("string_last %b, expected %b", tlast, want.string_last));
    endtask

    task check_leftovers();
        if (expected_units.size() != 0)
            report($sformatf("%0d code units never arrived", expected_units.size()));
    endtask
endclass

module utf8_decoder_bmp_core_test;

    // Cycles without a single transaction on either channel before we give up.
    // The longest honest quiet spell is one sender gap plus one receiver stall,
    // so this limit leaves a wide margin.
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned BYTE_BUDGET    = 420;
    localparam int unsigned QUIET_FROM     = 370;
    localparam int unsigned DRAIN_EVERY    = 120;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    bmp_decode_checker decoder_model = new();

    int unsigned bytes_sent;
    int unsigned idle_cycles;
    int unsigned stall_left;
    bit          quiet_tail;
    logic [7:0]  text_bytes [$];

    // The directed strings, each entry being {end_of_string, data_byte}.
    // They walk through plain ASCII, two- and three-byte boundaries, the
    // FFFF noncharacter, a surrogate encoding, the FDD0 noncharacter, a
    // four-byte sequence, an illegal lead byte followed by three strays (four
    // results from a single transaction) and a sequence cut short by the end
    // of the string.
    logic [8:0] directed_bytes [27] = '{
        9'h000, 9'h0C2, 9'h080, 9'h0DF, 9'h1BF,
        9'h0E0, 9'h0A0, 9'h080, 9'h0EF, 9'h0BF, 9'h1BF,
        9'h0ED, 9'h0A0, 9'h180,
        9'h0EF, 9'h0B7, 9'h090, 9'h0F0, 9'h090, 9'h080, 9'h180,
        9'h0F5, 9'h080, 9'h080, 9'h180,
        9'h0E2, 9'h182
    };

    utf8_decoder_bmp_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Both channels are sampled here, at the clock edge, before any of this
    // step's nonblocking updates land. An accepted byte is always noted
    // before a result in the same edge, although the block's registered
    // output means a byte can never produce a result at its own edge anyway.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) decoder_model.take_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) decoder_model.check_unit(m_tdata, m_tlast, m_tuser);
        end
    end

    // The watchdog restarts its count on every transaction, so that only a
    // genuine hang of either channel ends the run here.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // The receiver stalls in random bursts, and not at all once the closing part
    // of the run has begun. Exactly one assignment to m_tready is made per edge.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 18) - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offers one byte and returns at the edge at which it is accepted. The
    // valid flag is left high, so back-to-back transactions need no second
    // assignment in the same step.
    task automatic send_byte(input logic [7:0] data, input logic eos);
        s_tdata  <= data;
        s_tlast  <= eos;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic sender_gap(input int unsigned cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Random gap between transactions, suppressed during the closing part.
    task automatic maybe_gap();
        if (!quiet_tail && $urandom_range(0, 7) == 0) sender_gap($urandom_range(1, 18));
    endtask

    // The sender holds back until every code unit that is owed has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (decoder_model.outstanding() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(u8bmp_pkg::CONT_MIN, u8bmp_pkg::CONT_MAX));
    endfunction

    // Adds one byte to the end of the text being built.
    function automatic void add_byte(input logic [7:0] b);
        text_bytes = {text_bytes, b};
    endfunction

    // Appends one random character to the text being built. Most characters
    // are well-formed so that the decoder spends its time past the lead byte;
    // the rest are noise, cut-short sequences and broken continuations.
    function automatic void push_char();
        logic [7:0]  lead;
        int unsigned pick;
        int unsigned keep;
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            add_byte(8'($urandom_range(8'h00, 8'h7F)));
        end else if (pick < 48) begin
            add_byte(8'($urandom_range(u8bmp_pkg::LEAD_MIN, 8'hDF)));
            add_byte(cont_byte());
        end else if (pick < 68) begin
            lead = 8'($urandom_range(u8bmp_pkg::LEAD_E0, 8'hEF));
            add_byte(lead);
            if (lead == u8bmp_pkg::LEAD_E0) begin
                add_byte(8'($urandom_range(u8bmp_pkg::E0_MIN, u8bmp_pkg::CONT_MAX)));
            end else if (lead == u8bmp_pkg::LEAD_ED) begin
                add_byte(8'($urandom_range(u8bmp_pkg::CONT_MIN, u8bmp_pkg::ED_MAX)));
            end else begin
                add_byte(cont_byte());
            end
            add_byte(cont_byte());
        end else if (pick < 76) begin
            lead = 8'($urandom_range(u8bmp_pkg::LEAD_F0, u8bmp_pkg::LEAD_F4));
            add_byte(lead);
            if (lead == u8bmp_pkg::LEAD_F0) begin
                add_byte(8'($urandom_range(u8bmp_pkg::F0_MIN, u8bmp_pkg::CONT_MAX)));
            end else if (lead == u8bmp_pkg::LEAD_F4) begin
                add_byte(8'($urandom_range(u8bmp_pkg::CONT_MIN, u8bmp_pkg::F4_MAX)));
            end else begin
                add_byte(cont_byte());
            end
            add_byte(cont_byte());
            add_byte(cont_byte());
        end else if (pick < 82) begin
            // Noncharacters: the FDD0 to FDEF block, or FFFE and FFFF.
            add_byte(8'hEF);
            if ($urandom_range(0, 1) == 0) begin
                add_byte(8'hB7);
                add_byte(8'($urandom_range(8'h90, 8'hAF)));
            end else begin
                add_byte(8'hBF);
                add_byte(8'($urandom_range(8'hBE, 8'hBF)));
            end
        end else if (pick < 89) begin
            add_byte(8'($urandom_range(8'h00, 8'hFF)));
        end else if (pick < 94) begin
            // A lead byte with up to two continuation bytes behind it, often too few.
            lead = 8'($urandom_range(u8bmp_pkg::LEAD_MIN, 8'hFF));
            keep = $urandom_range(0, 2);
            add_byte(lead);
            repeat (keep) add_byte(cont_byte());
        end else if (pick < 97) begin
            // Surrogate halves, over-long forms and over-range forms.
            case ($urandom_range(0, 2))
                0: begin
                    add_byte(u8bmp_pkg::LEAD_ED);
                    add_byte(8'($urandom_range(8'hA0, u8bmp_pkg::CONT_MAX)));
                end
                1: begin
                    add_byte(8'($urandom_range(8'hC0, 8'hC1)));
                end
                default: begin
                    add_byte(8'($urandom_range(8'hF5, 8'hFF)));
                end
            endcase
            add_byte(cont_byte());
        end else begin
            // A good lead byte whose continuation is replaced by a non-continuation.
            add_byte(8'($urandom_range(u8bmp_pkg::LEAD_MIN, u8bmp_pkg::LEAD_F4)));
            if ($urandom_range(0, 1) == 0) begin
                add_byte(8'($urandom_range(8'h00, 8'h7F)));
            end else begin
                add_byte(8'($urandom_range(8'hC0, 8'hFF)));
            end
        end
    endfunction

    initial begin
        int unsigned next_drain;
        int unsigned chars;

        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= 8'h00;
        s_tlast    <= 1'b0;
        m_tready   <= 1'b0;
        bytes_sent  = 0;
        idle_cycles = 0;
        stall_left  = 0;
        quiet_tail  = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed strings first, with random gaps so that even these meet
        // stalls at various points of a sequence.
        foreach (directed_bytes[i]) begin
            send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
            maybe_gap();
        end
        drain_results();

        // Random strings of one to eight characters, the end of the string
        // always marked on the final byte. Now and then the sender waits for
        // the result channel to empty completely.
        next_drain = bytes_sent + DRAIN_EVERY;
        while (bytes_sent < BYTE_BUDGET) begin
            if (bytes_sent >= QUIET_FROM) quiet_tail = 1'b1;
            text_bytes.delete();
            chars = $urandom_range(1, 8);
            repeat (chars) push_char();
            foreach (text_bytes[i]) begin
                send_byte(text_bytes[i], i == text_bytes.size() - 1);
                maybe_gap();
            end
            if (bytes_sent >= next_drain && !quiet_tail) begin
                drain_results();
                next_drain = bytes_sent + DRAIN_EVERY;
            end
        end

        // Let the last code units come out, then keep watching the result channel
        // in case the block produces anything it should not.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (decoder_model.outstanding() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        decoder_model.check_leftovers();

        if (decoder_model.fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
